[sv/cir_pkg.sv]
// cir_pkg: shared types and constants of the cubic interpolation resampler
// used by the front, queue, back and top level files; no dependencies
package cir_pkg;

   localparam int SAMPLE_BITS         = 16;
   localparam int COEFF_FRAC_BITS     = 14;
   localparam int COEFF_BITS          = COEFF_FRAC_BITS + 2;
   localparam int TABLE_ROWS_DEFAULT  = 256;
   localparam int MAX_OUTPUTS_DEFAULT = 64;
   localparam int STEP_BITS           = 40;
   localparam int PHASE_BITS          = 64;
   localparam int INDEX_BITS          = 32;
   localparam int TDATA_BITS          = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 40'h01_0000_0000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // one accepted sample with the window as it stands after the shift
   typedef struct packed {
      sample_type [3:0]        win;
      sample_type              first;
      logic [INDEX_BITS-1:0]   index;
      logic                    eob;
   } step_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_MAC,
      BK_SUM,
      BK_EMIT
   } back_state_type;

endpackage

[sv/cubic_interp_resampler_top.sv]
// Cubic resampler top: step register, front (window, index), two-entry queue, back.
// Each point passes scan, four mac, sum and emit; emit waits while the held point
// cannot leave. Each sample adds idle and a final scan, and with end of buffer the
// scan runs on to r = 2; input stalls while two samples queue. A point leaves at the
// next emit or final scan.
// Synchronous reset clears window, counters, phase, queue and output; step is 1.0.
module cubic_interp_resampler_top #(
   parameter int TABLE_ROWS  = cir_pkg::TABLE_ROWS_DEFAULT,
   parameter int MAX_OUTPUTS = cir_pkg::MAX_OUTPUTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cir_pkg::TDATA_BITS-1:0]    req_tdata,  // sample
   input  logic                              req_tlast,  // end_of_buffer
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cir_pkg::TDATA_BITS-1:0]    rsp_tdata,  // value
   output logic                              rsp_tlast,  // last_of_run
   output logic                              rsp_tuser,  // buffer_done
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cir_pkg::STEP_BITS-1:0]     csr_data    // phase_step
);

   logic [cir_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic                            push;
   cir_pkg::step_entry_type         push_entry;
   logic                            queue_full;
   logic                            pop;
   logic                            head_valid;
   cir_pkg::step_entry_type         head_entry;

   assign csr_ready = 1'b1;
   assign step_in   = (csr_valid && csr_ready) ? csr_data : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= cir_pkg::STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   cir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   cir_back #(
      .TABLE_ROWS  (TABLE_ROWS),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .phase_step (step_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/cir_front.sv]
// cir_front: accepts source samples, keeps the four-sample window and the
// per-buffer sample index, and pushes one step entry per transaction
// depends on cir_pkg
module cir_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cir_pkg::TDATA_BITS-1:0]    req_tdata,  // sample
   input  logic                              req_tlast,  // end_of_buffer
   input  logic                              queue_full,
   output logic                              push,
   output cir_pkg::step_entry_type           push_entry
);

   cir_pkg::sample_type [3:0]          win_ff, win_in;
   cir_pkg::sample_type                first_ff, first_in;
   logic [cir_pkg::INDEX_BITS-1:0]     index_ff, index_in;
   cir_pkg::sample_type                sample;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign sample     = cir_pkg::sample_type'(req_tdata[cir_pkg::SAMPLE_BITS-1:0]);

   always_comb begin
      push_entry.win[0] = win_ff[1];
      push_entry.win[1] = win_ff[2];
      push_entry.win[2] = win_ff[3];
      push_entry.win[3] = sample;
      push_entry.first  = (index_ff == '0) ? sample : first_ff;
      push_entry.index  = index_ff;
      push_entry.eob    = req_tlast;

      win_in   = win_ff;
      first_in = first_ff;
      index_in = index_ff;
      if (push) begin
         if (req_tlast) begin
            win_in   = '0;
            first_in = '0;
            index_in = '0;
         end else begin
            win_in   = push_entry.win;
            first_in = push_entry.first;
            index_in = index_ff + cir_pkg::INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         first_ff <= '0;
         index_ff <= '0;
      end else begin
         win_ff   <= win_in;
         first_ff <= first_in;
         index_ff <= index_in;
      end
   end

endmodule

[sv/cir_queue.sv]
// cir_queue: two-entry queue of step entries between front and back
// depends on cir_pkg
module cir_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cir_pkg::step_entry_type   push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output cir_pkg::step_entry_type   head_entry
);

   localparam int DEPTH = 2;
   localparam int CW    = $clog2(DEPTH + 1);

   cir_pkg::step_entry_type   mem_ff [DEPTH];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]             count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/cir_back.sv]
// cir_back: phase accumulator, coefficient table, shared multiply-accumulate
// and result register; walks each step entry and emits its points
// depends on cir_pkg
module cir_back #(
   parameter int TABLE_ROWS  = cir_pkg::TABLE_ROWS_DEFAULT,
   parameter int MAX_OUTPUTS = cir_pkg::MAX_OUTPUTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cir_pkg::STEP_BITS-1:0]     phase_step,
   input  logic                              head_valid,
   input  cir_pkg::step_entry_type           head_entry,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cir_pkg::TDATA_BITS-1:0]    rsp_tdata,  // value
   output logic                              rsp_tlast,  // last_of_run
   output logic                              rsp_tuser   // buffer_done
);

   localparam int SB   = cir_pkg::SAMPLE_BITS;
   localparam int CF   = cir_pkg::COEFF_FRAC_BITS;
   localparam int CB   = cir_pkg::COEFF_BITS;
   localparam int PB   = cir_pkg::PHASE_BITS;
   localparam int RW   = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam int RMW  = 32 + $clog2(TABLE_ROWS + 1);
   localparam int CNTW = $clog2(MAX_OUTPUTS + 1);
   localparam int PW   = CB + SB;
   localparam int AW   = PW + 2;

   localparam longint ONE  = longint'(1) << CF;
   localparam longint NR   = longint'(TABLE_ROWS);
   localparam longint DEN  = 2 * NR * NR * NR;
   localparam logic signed [AW-1:0] RND  = AW'(longint'(1) << (CF - 1));
   localparam logic signed [AW-1:0] MAXV = AW'((longint'(1) << (SB - 1)) - 1);
   localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);

   // coefficient table, row r at x = r / TABLE_ROWS
   logic signed [CB-1:0] rom_c [TABLE_ROWS][4];

   for (genvar gi = 0; gi < TABLE_ROWS; gi++) begin : g_row
      for (genvar gt = 0; gt < 4; gt++) begin : g_tap
         localparam longint I   = longint'(gi);
         localparam longint NUM =
            (gt == 0) ? (-I * NR * NR + 2 * I * I * NR - I * I * I) :
            (gt == 1) ? (2 * NR * NR * NR - 5 * I * I * NR + 3 * I * I * I) :
            (gt == 2) ? (I * NR * NR + 4 * I * I * NR - 3 * I * I * I) :
                        (I * I * I - I * I * NR);
         localparam longint SCALED = NUM * ONE;
         localparam longint MAG    = (SCALED < 0) ? -SCALED : SCALED;
         localparam longint QUO    = (MAG + DEN / 2) / DEN;
         assign rom_c[gi][gt] = CB'((SCALED < 0) ? -QUO : QUO);
      end
   end

   cir_pkg::back_state_type    state_ff, state_in;
   logic [1:0]                 r_ff, r_in;
   logic [1:0]                 t_ff, t_in;
   logic [PB-1:0]              phase_ff, phase_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;
   logic                       hold_valid_ff, hold_valid_in;
   logic                       out_valid_ff, out_valid_in;

   logic [RW-1:0]              row_ff, row_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic signed [AW-1:0]       acc_ff, acc_in;
   logic [SB-1:0]              hold_value_ff, hold_value_in;
   logic                       hold_done_ff, hold_done_in;
   logic [SB-1:0]              out_value_ff, out_value_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_done_ff, out_done_in;

   logic [32:0]                sum_nr;
   logic [32:0]                target;
   logic                       valid_r;
   logic                       match;
   logic [1:0]                 last_r;
   logic [2:0]                 kk;
   logic [1:0]                 idx;
   cir_pkg::sample_type        tap;
   logic signed [CB-1:0]       coef;
   logic [RMW-1:0]             row_prod;
   logic signed [AW-1:0]       rnd;
   logic signed [AW-1:0]       shifted;
   logic [SB-1:0]              sat;
   logic                       out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = cir_pkg::TDATA_BITS'(out_value_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      sum_nr   = {1'b0, head_entry.index} + 33'(r_ff);
      valid_r  = (sum_nr >= 33'd2);
      target   = sum_nr - 33'd2;
      match    = valid_r && ({1'b0, phase_ff[PB-1:32]} == target) &&
                 (cnt_ff < CNTW'(MAX_OUTPUTS));
      last_r   = head_entry.eob ? 2'd2 : 2'd0;
      row_prod = RMW'(phase_ff[31:0]) * RMW'(TABLE_ROWS);
      kk       = 3'(r_ff) + 3'(t_ff);
      idx      = (kk > 3'd3) ? 2'd3 : kk[1:0];
      tap      = (t_ff == 2'd0 && sum_nr == 33'd2) ? head_entry.first
                                                    : head_entry.win[idx];
      coef     = rom_c[row_ff][t_ff];
      prod_in  = PW'(coef) * PW'(tap);
      rnd      = acc_ff + RND;
      shifted  = rnd >>> CF;
      if (shifted > MAXV) begin
         sat = MAXV[SB-1:0];
      end else if (shifted < MINV) begin
         sat = MINV[SB-1:0];
      end else begin
         sat = shifted[SB-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      t_in          = t_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      acc_in        = acc_ff;
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      hold_done_in  = hold_done_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      pop           = 1'b0;

      case (state_ff)
         cir_pkg::BK_IDLE: begin
            if (head_valid) begin
               r_in     = 2'd0;
               state_in = cir_pkg::BK_SCAN;
            end
         end
         cir_pkg::BK_SCAN: begin
            if (match) begin
               row_in   = row_prod[32 +: RW];
               t_in     = 2'd0;
               state_in = cir_pkg::BK_MAC;
            end else if (r_ff != last_r) begin
               r_in = r_ff + 2'd1;
            end else if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_value_in = hold_value_ff;
                  out_last_in  = 1'b1;
                  out_done_in  = hold_done_ff || head_entry.eob;
               end
               hold_valid_in = 1'b0;
               pop           = 1'b1;
               if (head_entry.eob) begin
                  phase_in = '0;
                  cnt_in   = '0;
               end
               state_in = cir_pkg::BK_IDLE;
            end
         end
         cir_pkg::BK_MAC: begin
            acc_in = (t_ff == 2'd0) ? '0 : acc_ff + AW'(prod_ff);
            t_in   = t_ff + 2'd1;
            if (t_ff == 2'd3) begin
               state_in = cir_pkg::BK_SUM;
            end
         end
         cir_pkg::BK_SUM: begin
            acc_in   = acc_ff + AW'(prod_ff);
            state_in = cir_pkg::BK_EMIT;
         end
         cir_pkg::BK_EMIT: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_value_in = hold_value_ff;
                  out_last_in  = 1'b0;
                  out_done_in  = hold_done_ff;
               end
               hold_valid_in = 1'b1;
               hold_value_in = sat;
               hold_done_in  = ((cnt_ff + CNTW'(1)) == CNTW'(MAX_OUTPUTS));
               cnt_in        = cnt_ff + CNTW'(1);
               phase_in      = phase_ff + PB'(phase_step);
               state_in      = cir_pkg::BK_SCAN;
            end
         end
         default: begin
            state_in = cir_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cir_pkg::BK_IDLE;
         r_ff          <= '0;
         t_ff          <= '0;
         phase_ff      <= '0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         r_ff          <= r_in;
         t_ff          <= t_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      hold_value_ff <= hold_value_in;
      hold_done_ff  <= hold_done_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

endmodule

[sv/cir_checker.sv]
// cir_assert_checker: port-level checks of the resampler result stream, bound to
// the top level; depends on cir_pkg
module cir_assert_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [cir_pkg::TDATA_BITS-1:0]    rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              rsp_tuser
);

   // a buffer-done transaction always closes its run
   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("buffer done without last of run");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // empty queue right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind cubic_interp_resampler_top cir_assert_checker u_checker (.*);
